@@ src/ps2_mouse_device_command_engine_top_macros.svh @@
// Assertion helpers; expect clk and rst_n in scope.
`ifndef PS2_MOUSE_DEVICE_COMMAND_ENGINE_TOP_MACROS_SVH
`define PS2_MOUSE_DEVICE_COMMAND_ENGINE_TOP_MACROS_SVH

`define PS2M_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ps2m assertion failed");

`define PS2M_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ps2m assertion failed");

`endif

@@ src/ps2m_pkg.sv @@
package ps2m_pkg;

  localparam int MAX_RES_CODE     = 3;
  localparam int RES_W            = $clog2(MAX_RES_CODE + 1);
  localparam int TICKS_PER_SECOND = 1000;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_MOVE = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  localparam logic [7:0] CMD_RESET    = 8'hFF;
  localparam logic [7:0] CMD_RESEND   = 8'hFE;
  localparam logic [7:0] CMD_DEFAULTS = 8'hF6;
  localparam logic [7:0] CMD_REP_OFF  = 8'hF5;
  localparam logic [7:0] CMD_REP_ON   = 8'hF4;
  localparam logic [7:0] CMD_SET_RATE = 8'hF3;
  localparam logic [7:0] CMD_GET_ID   = 8'hF2;
  localparam logic [7:0] CMD_REMOTE   = 8'hF0;
  localparam logic [7:0] CMD_WRAP_OFF = 8'hEC;
  localparam logic [7:0] CMD_READ     = 8'hEB;
  localparam logic [7:0] CMD_STREAM   = 8'hEA;
  localparam logic [7:0] CMD_STATUS   = 8'hE9;
  localparam logic [7:0] CMD_SET_RES  = 8'hE8;
  localparam logic [7:0] CMD_SCALE2   = 8'hE7;
  localparam logic [7:0] CMD_SCALE1   = 8'hE6;
  localparam logic [7:0] CMD_WRAP     = 8'hEE;

  localparam logic [7:0] ACK_BYTE = 8'hFA;
  localparam logic [7:0] BAT_BYTE = 8'hAA;

  localparam logic [7:0] RST_RATE = 8'd100;
  localparam logic [1:0] RST_RES  = 2'd2;
  localparam logic [7:0] RST_ID   = 8'd0;

  localparam logic [1:0] REG_RATE = 2'd0;
  localparam logic [1:0] REG_RES  = 2'd1;
  localparam logic [1:0] REG_ID   = 2'd2;

  typedef enum logic [4:0] {
    OP_RESET, OP_DEFAULTS, OP_RESEND, OP_GET_ID, OP_STREAM, OP_REMOTE,
    OP_WRAP, OP_SCALE1, OP_SCALE2, OP_SET_RES, OP_SET_RATE, OP_REP_ON,
    OP_REP_OFF, OP_STATUS, OP_READ, OP_OTHER, OP_MOVE, OP_TICK, OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    PEND_NONE, PEND_WRAP, PEND_RES, PEND_RATE
  } pend_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_TPROD, ST_TDEC, ST_SEND
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] host_byte;
    logic [7:0] move_x;
    logic [7:0] move_y;
    logic [2:0] buttons;
  } item_t;

  typedef struct packed {
    logic [7:0]     def_rate;
    logic [1:0]     def_res;
    logic [7:0]     dev_id;
  } cfg_t;

endpackage

@@ src/ps2m_if.sv @@
interface ps2m_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [7:0]        host_byte;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;
  logic              button_left;
  logic              button_right;
  logic              button_middle;

  modport source (output valid, kind, host_byte, move_x, move_y,
                  button_left, button_right, button_middle, input ready);
  modport sink   (input valid, kind, host_byte, move_x, move_y,
                  button_left, button_right, button_middle, output ready);
endinterface

interface ps2m_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

@@ src/ps2m_front.sv @@
module ps2m_front (
  input  logic            clk,
  input  logic            rst_n,
  ps2m_in_if.sink         in_ch,
  output logic            deq_valid,
  input  logic            deq_ready,
  output ps2m_pkg::item_t deq_item
);

  localparam int PW = $clog2(ps2m_pkg::QUEUE_DEPTH);

  ps2m_pkg::item_t q_r [ps2m_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r, cnt_nxt;
  ps2m_pkg::item_t cls;
  logic            push, pop;

  always_comb begin
    cls.host_byte = in_ch.host_byte;
    cls.move_x    = in_ch.move_x;
    cls.move_y    = in_ch.move_y;
    cls.buttons   = {in_ch.button_middle, in_ch.button_right, in_ch.button_left};
    case (in_ch.kind)
      ps2m_pkg::KIND_CMD: begin
        case (in_ch.host_byte)
          ps2m_pkg::CMD_RESET:    cls.op = ps2m_pkg::OP_RESET;
          ps2m_pkg::CMD_DEFAULTS: cls.op = ps2m_pkg::OP_DEFAULTS;
          ps2m_pkg::CMD_RESEND:   cls.op = ps2m_pkg::OP_RESEND;
          ps2m_pkg::CMD_GET_ID:   cls.op = ps2m_pkg::OP_GET_ID;
          ps2m_pkg::CMD_STREAM:   cls.op = ps2m_pkg::OP_STREAM;
          ps2m_pkg::CMD_REMOTE:   cls.op = ps2m_pkg::OP_REMOTE;
          ps2m_pkg::CMD_WRAP:     cls.op = ps2m_pkg::OP_WRAP;
          ps2m_pkg::CMD_SCALE1:   cls.op = ps2m_pkg::OP_SCALE1;
          ps2m_pkg::CMD_SCALE2:   cls.op = ps2m_pkg::OP_SCALE2;
          ps2m_pkg::CMD_SET_RES:  cls.op = ps2m_pkg::OP_SET_RES;
          ps2m_pkg::CMD_SET_RATE: cls.op = ps2m_pkg::OP_SET_RATE;
          ps2m_pkg::CMD_REP_ON:   cls.op = ps2m_pkg::OP_REP_ON;
          ps2m_pkg::CMD_REP_OFF:  cls.op = ps2m_pkg::OP_REP_OFF;
          ps2m_pkg::CMD_STATUS:   cls.op = ps2m_pkg::OP_STATUS;
          ps2m_pkg::CMD_READ:     cls.op = ps2m_pkg::OP_READ;
          default:                cls.op = ps2m_pkg::OP_OTHER;
        endcase
      end
      ps2m_pkg::KIND_MOVE: cls.op = ps2m_pkg::OP_MOVE;
      ps2m_pkg::KIND_TICK: cls.op = ps2m_pkg::OP_TICK;
      default:             cls.op = ps2m_pkg::OP_NONE;
    endcase
  end

  assign in_ch.ready = (cnt_r != (PW+1)'(ps2m_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready && (cls.op != ps2m_pkg::OP_NONE);
  assign deq_valid   = (cnt_r != '0);
  assign pop         = deq_valid && deq_ready;
  assign deq_item    = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

@@ src/ps2m_back.sv @@
`include "ps2_mouse_device_command_engine_top_macros.svh"

module ps2m_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ps2m_pkg::cfg_t  cfg,
  input  logic            deq_valid,
  output logic            deq_ready,
  input  ps2m_pkg::item_t deq_item,
  ps2m_out_if.source      out_ch
);

  localparam int RW = ps2m_pkg::RES_W;
  localparam int PRW = 25;

  ps2m_pkg::state_t state_r, state_nxt;
  ps2m_pkg::item_t  item_r;
  ps2m_pkg::pend_t  pend_r, pend_nxt;
  logic             stream_r, stream_nxt;
  logic             report_r, report_nxt;
  logic             scale_r, scale_nxt;
  logic [7:0]       rate_r, rate_nxt;
  logic [RW-1:0]    res_r, res_nxt;
  logic [7:0]       hx_r, hx_nxt, hy_r, hy_nxt;
  logic [2:0]       hb_r, hb_nxt;
  logic             chg_r, chg_nxt;
  logic [15:0]      ms_r, ms_nxt;
  logic [7:0]       rep_r [4];
  logic [7:0]       rep_nxt [4];
  logic [2:0]       len_r, len_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic [PRW-1:0]   prod_r, prod_nxt;
  logic             ov_r, ov_nxt;
  logic [7:0]       ob_r, ob_nxt;
  logic             ol_r, ol_nxt;
  logic             go_send, send_pkt, load_out, is_last;
  logic [7:0]       rate_eff;
  logic [23:0]      pkt_s, pkt_d;
  logic [RW-1:0]    def_res_c;

  function automatic logic [7:0] mag(input logic [7:0] v);
    mag = v[7] ? 8'(9'h100 - {1'b0, v}) : v;
  endfunction

  function automatic logic [7:0] shrink(input logic [7:0] raw, input logic [RW-1:0] res);
    logic [7:0] m;
    int steps;
    m = mag(raw);
    steps = (int'(res) < ps2m_pkg::MAX_RES_CODE) ? (ps2m_pkg::MAX_RES_CODE - int'(res)) : 0;
    for (int i = 0; i < ps2m_pkg::MAX_RES_CODE; i++) begin
      if (i < steps) begin
        m = (m >> 1) | {7'd0, m[0]};
      end
    end
    shrink = raw[7] ? 8'(9'h100 - {1'b0, m}) : m;
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] m);
    case (m)
      8'd0:    dbl = 8'd0;
      8'd1:    dbl = 8'd1;
      8'd2:    dbl = 8'd1;
      8'd3:    dbl = 8'd3;
      8'd4:    dbl = 8'd6;
      8'd5:    dbl = 8'd9;
      default: dbl = m[7] ? 8'hFF : {m[6:0], 1'b0};
    endcase
  endfunction

  function automatic logic [23:0] packet(input logic [7:0] x, input logic [7:0] y,
                                         input logic [2:0] b, input logic two);
    logic [7:0] ax, ay, p0;
    ax = two ? dbl(mag(x)) : mag(x);
    ay = two ? dbl(mag(y)) : mag(y);
    p0 = {ay > 8'd128, ax > 8'd128, y[7], x[7], 1'b1, b[2], b[1], b[0]};
    packet = {p0,
              x[7] ? 8'(9'h100 - {1'b0, ax}) : ax,
              y[7] ? 8'(9'h100 - {1'b0, ay}) : ay};
  endfunction

  assign def_res_c = (int'(cfg.def_res) > ps2m_pkg::MAX_RES_CODE) ?
                     RW'(ps2m_pkg::MAX_RES_CODE) : RW'(cfg.def_res);
  assign rate_eff  = (rate_r == 8'd0) ? 8'd1 : rate_r;
  assign pkt_s     = packet(hx_r, hy_r, hb_r, 1'b0);
  assign pkt_d     = packet(hx_r, hy_r, hb_r, scale_r);
  assign send_pkt  = chg_r && stream_r && report_r && (pend_r == ps2m_pkg::PEND_NONE) &&
                     (prod_r > PRW'(ps2m_pkg::TICKS_PER_SECOND));
  assign load_out  = (state_r == ps2m_pkg::ST_SEND) && (!ov_r || out_ch.ready);
  assign is_last   = ({1'b0, idx_r} == (len_r - 3'd1));
  assign deq_ready = (state_r == ps2m_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ps2m_pkg::ST_IDLE:  if (deq_valid) state_nxt = ps2m_pkg::ST_EXEC;
      ps2m_pkg::ST_EXEC: begin
        if (item_r.op == ps2m_pkg::OP_TICK) begin
          state_nxt = ps2m_pkg::ST_TPROD;
        end else begin
          state_nxt = go_send ? ps2m_pkg::ST_SEND : ps2m_pkg::ST_IDLE;
        end
      end
      ps2m_pkg::ST_TPROD: state_nxt = ps2m_pkg::ST_TDEC;
      ps2m_pkg::ST_TDEC:  state_nxt = send_pkt ? ps2m_pkg::ST_SEND : ps2m_pkg::ST_IDLE;
      ps2m_pkg::ST_SEND:  if (load_out && is_last) state_nxt = ps2m_pkg::ST_IDLE;
      default:            state_nxt = ps2m_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pend_nxt   = pend_r;
    stream_nxt = stream_r;
    report_nxt = report_r;
    scale_nxt  = scale_r;
    rate_nxt   = rate_r;
    res_nxt    = res_r;
    hx_nxt     = hx_r;
    hy_nxt     = hy_r;
    hb_nxt     = hb_r;
    chg_nxt    = chg_r;
    ms_nxt     = ms_r;
    rep_nxt    = rep_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    prod_nxt   = prod_r;
    ov_nxt     = ov_r && !out_ch.ready;
    ob_nxt     = ob_r;
    ol_nxt     = ol_r;
    go_send    = 1'b0;
    case (state_r)
      ps2m_pkg::ST_EXEC: begin
        case (item_r.op)
          ps2m_pkg::OP_MOVE: begin
            hx_nxt  = shrink(item_r.move_x, res_r);
            hy_nxt  = shrink(item_r.move_y, res_r);
            hb_nxt  = item_r.buttons;
            chg_nxt = 1'b1;
          end
          ps2m_pkg::OP_TICK: begin
            if (ms_r != 16'hFFFF) ms_nxt = ms_r + 16'd1;
          end
          default: begin
            go_send    = 1'b1;
            len_nxt    = 3'd1;
            rep_nxt[0] = ps2m_pkg::ACK_BYTE;
            if (item_r.host_byte == ps2m_pkg::CMD_RESET) begin
              stream_nxt = 1'b1;
              report_nxt = 1'b0;
              scale_nxt  = 1'b0;
              rate_nxt   = cfg.def_rate;
              res_nxt    = def_res_c;
              pend_nxt   = ps2m_pkg::PEND_NONE;
              chg_nxt    = 1'b0;
              ms_nxt     = '0;
              rep_nxt[1] = ps2m_pkg::BAT_BYTE;
              rep_nxt[2] = cfg.dev_id;
              len_nxt    = 3'd3;
            end else if (pend_r == ps2m_pkg::PEND_WRAP) begin
              if (item_r.host_byte == ps2m_pkg::CMD_WRAP_OFF) begin
                pend_nxt = ps2m_pkg::PEND_NONE;
              end else begin
                rep_nxt[0] = item_r.host_byte;
              end
            end else if (pend_r == ps2m_pkg::PEND_RES) begin
              res_nxt  = (int'(item_r.host_byte) > ps2m_pkg::MAX_RES_CODE) ?
                         RW'(ps2m_pkg::MAX_RES_CODE) : RW'(item_r.host_byte);
              pend_nxt = ps2m_pkg::PEND_NONE;
            end else if (pend_r == ps2m_pkg::PEND_RATE) begin
              rate_nxt = item_r.host_byte;
              pend_nxt = ps2m_pkg::PEND_NONE;
            end else begin
              case (item_r.op)
                ps2m_pkg::OP_DEFAULTS: begin
                  stream_nxt = 1'b1;
                  report_nxt = 1'b0;
                  scale_nxt  = 1'b0;
                  rate_nxt   = cfg.def_rate;
                  res_nxt    = def_res_c;
                  chg_nxt    = 1'b0;
                  ms_nxt     = '0;
                end
                ps2m_pkg::OP_RESEND: begin
                  len_nxt = len_r;
                  rep_nxt = rep_r;
                  go_send = (len_r != 3'd0);
                end
                ps2m_pkg::OP_GET_ID: begin
                  rep_nxt[1] = cfg.dev_id;
                  len_nxt    = 3'd2;
                end
                ps2m_pkg::OP_STREAM:   stream_nxt = 1'b1;
                ps2m_pkg::OP_REMOTE:   stream_nxt = 1'b0;
                ps2m_pkg::OP_WRAP:     pend_nxt = ps2m_pkg::PEND_WRAP;
                ps2m_pkg::OP_SCALE1:   scale_nxt = 1'b0;
                ps2m_pkg::OP_SCALE2:   scale_nxt = 1'b1;
                ps2m_pkg::OP_SET_RES:  pend_nxt = ps2m_pkg::PEND_RES;
                ps2m_pkg::OP_SET_RATE: pend_nxt = ps2m_pkg::PEND_RATE;
                ps2m_pkg::OP_REP_ON:   report_nxt = 1'b1;
                ps2m_pkg::OP_REP_OFF:  report_nxt = 1'b0;
                ps2m_pkg::OP_STATUS: begin
                  rep_nxt[1] = {1'b0, !stream_r, report_r, scale_r, 1'b0,
                                hb_r[0], hb_r[2], hb_r[1]};
                  rep_nxt[2] = 8'(res_r);
                  rep_nxt[3] = rate_r;
                  len_nxt    = 3'd4;
                end
                ps2m_pkg::OP_READ: begin
                  rep_nxt[1] = pkt_s[23:16];
                  rep_nxt[2] = pkt_s[15:8];
                  rep_nxt[3] = pkt_s[7:0];
                  len_nxt    = 3'd4;
                end
                default: ;
              endcase
            end
          end
        endcase
      end
      ps2m_pkg::ST_TPROD: begin
        prod_nxt = PRW'(({1'b0, ms_r} + 17'd1) * rate_eff);
      end
      ps2m_pkg::ST_TDEC: begin
        if (send_pkt) begin
          chg_nxt    = 1'b0;
          ms_nxt     = '0;
          rep_nxt[0] = pkt_d[23:16];
          rep_nxt[1] = pkt_d[15:8];
          rep_nxt[2] = pkt_d[7:0];
          len_nxt    = 3'd3;
        end
      end
      ps2m_pkg::ST_SEND: begin
        if (load_out) begin
          ov_nxt  = 1'b1;
          ob_nxt  = rep_r[idx_r];
          ol_nxt  = is_last;
          idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ps2m_pkg::ST_IDLE;
      pend_r   <= ps2m_pkg::PEND_NONE;
      stream_r <= 1'b1;
      report_r <= 1'b0;
      scale_r  <= 1'b0;
      rate_r   <= ps2m_pkg::RST_RATE;
      res_r    <= RW'(ps2m_pkg::RST_RES);
      hx_r     <= '0;
      hy_r     <= '0;
      hb_r     <= '0;
      chg_r    <= 1'b0;
      ms_r     <= '0;
      rep_r    <= '{default: '0};
      len_r    <= '0;
      idx_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pend_r   <= pend_nxt;
      stream_r <= stream_nxt;
      report_r <= report_nxt;
      scale_r  <= scale_nxt;
      rate_r   <= rate_nxt;
      res_r    <= res_nxt;
      hx_r     <= hx_nxt;
      hy_r     <= hy_nxt;
      hb_r     <= hb_nxt;
      chg_r    <= chg_nxt;
      ms_r     <= ms_nxt;
      rep_r    <= rep_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
    if (deq_valid && deq_ready) begin
      item_r <= deq_item;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.out_byte  = ob_r;
  assign out_ch.last_byte = ol_r;

  `PS2M_ASSERT_SAME(a_res_range, 1'b1, int'(res_r) <= ps2m_pkg::MAX_RES_CODE)
  `PS2M_ASSERT_SAME(a_send_len, state_r == ps2m_pkg::ST_SEND, len_r != 3'd0)
  `PS2M_ASSERT_NEXT(a_pkt_clear, (state_r == ps2m_pkg::ST_TDEC) && send_pkt, (ms_r == 16'd0) && !chg_r)

endmodule

@@ src/ps2_mouse_device_command_engine_top.sv @@
// channel | dir | transfer
// in_ch   | in  | one host byte, movement update or ms tick
// out_ch  | out | one reply byte, last_byte on the final byte of a run
// cfg_*   | in  | APB register write/read, always ready
// Back-end steps: move IDLE, EXEC; command IDLE, EXEC, SEND (reply bytes);
// tick IDLE, EXEC, TPROD, TDEC, SEND on a packet. Dequeues only in IDLE.
// A 2-entry queue lets input transfers continue while replies stall on out_ch.
// rst_n is synchronous; reset loads register defaults and clears the queue.
module ps2_mouse_device_command_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  ps2m_in_if.sink     in_ch,
  ps2m_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ps2m_pkg::cfg_t  cfg_r;
  ps2m_pkg::item_t deq_item;
  logic            deq_valid, deq_ready, wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.def_rate <= ps2m_pkg::RST_RATE;
      cfg_r.def_res  <= ps2m_pkg::RST_RES;
      cfg_r.dev_id   <= ps2m_pkg::RST_ID;
    end else if (wr) begin
      case (cfg_paddr[3:2])
        ps2m_pkg::REG_RATE: cfg_r.def_rate <= cfg_pwdata[7:0];
        ps2m_pkg::REG_RES:  cfg_r.def_res  <= cfg_pwdata[1:0];
        ps2m_pkg::REG_ID:   cfg_r.dev_id   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      ps2m_pkg::REG_RATE: cfg_prdata = {24'd0, cfg_r.def_rate};
      ps2m_pkg::REG_RES:  cfg_prdata = {30'd0, cfg_r.def_res};
      ps2m_pkg::REG_ID:   cfg_prdata = {24'd0, cfg_r.dev_id};
      default:            cfg_prdata = '0;
    endcase
  end

  ps2m_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_item  (deq_item)
  );

  ps2m_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_item  (deq_item),
    .out_ch    (out_ch)
  );

endmodule
